>>> rtl/multichannel_sine_sensor_source_defines.svh
// assertion helpers shared by the block
`ifndef MULTICHANNEL_SINE_SENSOR_SOURCE_DEFINES_SVH
`define MULTICHANNEL_SINE_SENSOR_SOURCE_DEFINES_SVH

// condition checked in the same cycle
`define MSS_ASSERT_NOW(label, cond, check, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (check)) \
		else $error(msg);

// condition checked in the cycle after it holds
`define MSS_ASSERT_NEXT(label, cond, check, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (check)) \
		else $error(msg);

`endif

>>> rtl/mss_pkg.sv
`default_nettype none

package mss_pkg;

	// block sizing
	localparam int CHANNELS           = 6;
	localparam int MAX_CHANNELS       = 6;
	localparam int PHASE_BITS         = 32;
	localparam int SINE_ADDR_BITS     = 10;
	localparam int SENSOR_MV_AT_220   = 800;
	localparam int CURRENT_MV_PER_AMP = 80;

	localparam int TABLE_SIZE   = 1 << SINE_ADDR_BITS;
	localparam int LEVELS       = CHANNELS + 1;
	localparam int LVL_IDX_BITS = (LEVELS > 1) ? $clog2(LEVELS) : 1;

	// field widths
	localparam int MAG_BITS      = 15;
	localparam int MV_BITS       = 13;
	localparam int VOLT_BITS     = 12;
	localparam int CUR_BITS      = 15;
	localparam int CFG_DATA_BITS = 32;
	localparam int REG_IDX_BITS  = 3;

	// output levels in millivolts
	localparam int BIAS_MV   = 2500;
	localparam int LEVEL_MIN = 20;
	localparam int LEVEL_MAX = 4980;
	localparam int OFF_MAX   = LEVEL_MAX - BIAS_MV;
	localparam int OFF_BITS  = $clog2(OFF_MAX + 1);

	// fixed point constants
	localparam int SQRT2_Q16    = 92682;
	localparam int SQRT2_BITS   = 17;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam int FRAC_SHIFT   = 31;
	localparam int V_DEN        = 2200;
	localparam int I_DEN        = 1000;

	function automatic int imax(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	// scaled amplitude factors: rms value times sensor gain
	localparam int VF_BITS = VOLT_BITS + $clog2(SENSOR_MV_AT_220 + 1);
	localparam int IF_BITS = CUR_BITS + $clog2(CURRENT_MV_PER_AMP + 1);
	localparam int F_BITS  = imax(VF_BITS, IF_BITS);

	// sine magnitude times sqrt2, then times factor
	localparam int BASE_BITS = MAG_BITS + SQRT2_BITS;
	localparam int P_BITS    = BASE_BITS + F_BITS;

	// rounded numerator, divided by a reciprocal multiply
	localparam int N_BITS = P_BITS - FRAC_SHIFT + 1;
	localparam int S_V    = N_BITS + $clog2(V_DEN);
	localparam int S_I    = N_BITS + $clog2(I_DEN);
	localparam longint unsigned M_V = ((64'd1 << S_V) + V_DEN - 1) / V_DEN;
	localparam longint unsigned M_I = ((64'd1 << S_I) + I_DEN - 1) / I_DEN;
	localparam int M_BITS = N_BITS + 1;

	// shared multiplier shape
	localparam int MUL_A_BITS = imax(BASE_BITS, N_BITS);
	localparam int MUL_B_BITS = imax(imax(F_BITS, M_BITS), SQRT2_BITS);
	localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;
	localparam int Q_V_BITS   = MUL_P_BITS - S_V;
	localparam int Q_I_BITS   = MUL_P_BITS - S_I;

	// register map
	localparam logic [REG_IDX_BITS-1:0] REG_PHASE_STEP    = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_VOLTAGE_RMS   = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_CURRENT_FIRST = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_CURRENT_LAST  = 3'd7;

	// register reset values
	localparam logic [31:0] STEP_RST    = 32'd53687091;
	localparam int          VOLT_RST_DV = 2200;
	localparam int          CUR_RST_MA [MAX_CHANNELS] = '{700, 1200, 350, 2400, 900, 1800};

	// amplitude factor per level, entry 0 is the voltage sensor
	typedef logic [LEVELS-1:0][F_BITS-1:0] factor_arr_t;

	// finished levels, entry 0 is the voltage sensor
	typedef logic [LEVELS-1:0][MV_BITS-1:0] lvl_arr_t;

	// sequencer status toward the port logic
	typedef struct packed {
		logic busy;
		logic done;
	} seq_stat_t;

	// quarter-wave entry k: sine at the middle of slot k, unsigned q0.15
	function automatic logic [MAG_BITS-1:0] sine_entry(input int k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		longint      s;
		longint      q;
		x  = (HALF_PI_Q30 * (64'(2 * k) + 64'd1)) >> (SINE_ADDR_BITS + 1);
		x2 = (x * x) >> 30;
		t  = x;
		s  = longint'(x);
		t  = ((t * x2) >> 30) / 64'd6;
		s  = s - longint'(t);
		t  = ((t * x2) >> 30) / 64'd20;
		s  = s + longint'(t);
		t  = ((t * x2) >> 30) / 64'd42;
		s  = s - longint'(t);
		t  = ((t * x2) >> 30) / 64'd72;
		s  = s + longint'(t);
		t  = ((t * x2) >> 30) / 64'd110;
		s  = s - longint'(t);
		t  = ((t * x2) >> 30) / 64'd156;
		s  = s + longint'(t);
		if (s < 0) begin
			s = 0;
		end
		q = (s + 64'sd16384) >>> 15;
		if (q > 32767) begin
			q = 32767;
		end
		return MAG_BITS'(q);
	endfunction

endpackage

`default_nettype wire

>>> rtl/mss_in_if.sv
`default_nettype none

// sample tick channel
interface mss_in_if;
	logic valid;
	logic ready;
	logic load_on;

	modport source (output valid, output load_on, input ready);
	modport sink (input valid, input load_on, output ready);
endinterface

`default_nettype wire

>>> rtl/mss_out_if.sv
`default_nettype none

// sensor level channel
interface mss_out_if;
	logic                        valid;
	logic                        ready;
	logic [mss_pkg::MV_BITS-1:0] voltage_mv;
	logic [mss_pkg::MV_BITS-1:0] current0_mv;
	logic [mss_pkg::MV_BITS-1:0] current1_mv;
	logic [mss_pkg::MV_BITS-1:0] current2_mv;
	logic [mss_pkg::MV_BITS-1:0] current3_mv;
	logic [mss_pkg::MV_BITS-1:0] current4_mv;
	logic [mss_pkg::MV_BITS-1:0] current5_mv;

	modport source (output valid, output voltage_mv, output current0_mv, output current1_mv,
		output current2_mv, output current3_mv, output current4_mv, output current5_mv,
		input ready);
	modport sink (input valid, input voltage_mv, input current0_mv, input current1_mv,
		input current2_mv, input current3_mv, input current4_mv, input current5_mv,
		output ready);
endinterface

`default_nettype wire

>>> rtl/multichannel_sine_sensor_source.sv
// Sine sensor source: each sample request advances a phase accumulator and yields one
// voltage-sensor level and six current-sensor levels in millivolts, 2500 mV bias plus the
// sensor peak amplitude times the sine of the phase held before the advance, clamped to
// 20..4980 mV; with load_on low the current levels stay at bias. A new request is accepted
// only once the previous result has moved to the output register. The work is done in
// turn on the single shared multiplier: one sine-times-sqrt2 product, then a scale and a
// reciprocal divide for each level, after a registered quarter-wave rom read. A finished
// result waits in the output register while the next request is taken. Registers are
// written through wr_en, wr_index and wr_data; the user must write them only while no
// request is in flight, which the block itself does not enforce. Current channels beyond
// CHANNELS ignore writes and output 2500 mV.
`default_nettype none

`include "multichannel_sine_sensor_source_defines.svh"

module multichannel_sine_sensor_source (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	mss_in_if.sink                                   sample,
	mss_out_if.source                                result,
	input  wire logic                                wr_en,
	input  wire logic [mss_pkg::REG_IDX_BITS-1:0]    wr_index,
	input  wire logic [mss_pkg::CFG_DATA_BITS-1:0]   wr_data
);

	logic [mss_pkg::PHASE_BITS-1:0] phase_q;
	logic [mss_pkg::PHASE_BITS-1:0] phase_next;
	logic [mss_pkg::PHASE_BITS-1:0] step_q;
	mss_pkg::factor_arr_t           factor_q;
	logic                           accept;
	logic                           take;
	mss_pkg::seq_stat_t             stat;
	mss_pkg::lvl_arr_t              lvl;
	logic                           out_valid_q;
	mss_pkg::lvl_arr_t              out_lvl_q;
	logic [mss_pkg::MAG_BITS-1:0]   mag;
	logic                           neg;
	logic [mss_pkg::MV_BITS-1:0]    cur_mv [mss_pkg::MAX_CHANNELS];
	logic                           out_stall;
	logic                           volt_ok;

	// request handshake
	assign sample.ready = !stat.busy;
	assign accept       = sample.valid && sample.ready;
	assign take         = stat.done && (!out_valid_q || result.ready);

	// register file, amplitudes kept as rms value times sensor gain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= mss_pkg::STEP_RST[mss_pkg::PHASE_BITS-1:0];
			factor_q[0] <= mss_pkg::F_BITS'(mss_pkg::VOLT_RST_DV * mss_pkg::SENSOR_MV_AT_220);
			for (int c = 0; c < mss_pkg::CHANNELS; c++) begin
				factor_q[c+1] <= mss_pkg::F_BITS'(mss_pkg::CUR_RST_MA[c]
					* mss_pkg::CURRENT_MV_PER_AMP);
			end
		end else if (wr_en) begin
			case (wr_index) inside
				mss_pkg::REG_PHASE_STEP: begin
					step_q <= wr_data[mss_pkg::PHASE_BITS-1:0];
				end
				mss_pkg::REG_VOLTAGE_RMS: begin
					factor_q[0] <= mss_pkg::F_BITS'(wr_data[mss_pkg::VOLT_BITS-1:0])
						* mss_pkg::F_BITS'(mss_pkg::SENSOR_MV_AT_220);
				end
				[mss_pkg::REG_CURRENT_FIRST:mss_pkg::REG_CURRENT_LAST]: begin
					for (int c = 0; c < mss_pkg::CHANNELS; c++) begin
						if (wr_index == mss_pkg::REG_CURRENT_FIRST
							+ mss_pkg::REG_IDX_BITS'(c)) begin
							factor_q[c+1] <= mss_pkg::F_BITS'(wr_data[mss_pkg::CUR_BITS-1:0])
								* mss_pkg::F_BITS'(mss_pkg::CURRENT_MV_PER_AMP);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// phase accumulator, advanced after the lookup of each request
	assign phase_next = phase_q + step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (accept) begin
			phase_q <= phase_next;
		end
	end

	mss_sine_lut u_lut (
		.clk   (clk),
		.rd_en (accept),
		.phase (phase_q),
		.mag_q (mag),
		.neg_q (neg)
	);

	mss_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.load_on (sample.load_on),
		.mag     (mag),
		.neg     (neg),
		.factor  (factor_q),
		.take    (take),
		.stat    (stat),
		.lvl     (lvl)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_lvl_q <= lvl;
		end
	end

	// unused current channels sit at bias
	for (genvar k = 0; k < mss_pkg::MAX_CHANNELS; k++) begin : g_cur
		if (k < mss_pkg::CHANNELS) begin : g_used
			assign cur_mv[k] = out_lvl_q[k+1];
		end else begin : g_unused
			assign cur_mv[k] = mss_pkg::MV_BITS'(mss_pkg::BIAS_MV);
		end
	end

	assign result.valid       = out_valid_q;
	assign result.voltage_mv  = out_lvl_q[0];
	assign result.current0_mv = cur_mv[0];
	assign result.current1_mv = cur_mv[1];
	assign result.current2_mv = cur_mv[2];
	assign result.current3_mv = cur_mv[3];
	assign result.current4_mv = cur_mv[4];
	assign result.current5_mv = cur_mv[5];

	// checks
	assign out_stall = out_valid_q && !result.ready;
	assign volt_ok   = out_lvl_q[0] >= mss_pkg::MV_BITS'(mss_pkg::LEVEL_MIN)
		&& out_lvl_q[0] <= mss_pkg::MV_BITS'(mss_pkg::LEVEL_MAX);

	`MSS_ASSERT_NEXT(a_accept_starts, accept, stat.busy, "request did not start the sequencer")
	`MSS_ASSERT_NEXT(a_phase_advance, accept, phase_q == $past(phase_next), "phase step missed")
	`MSS_ASSERT_NEXT(a_result_kept, stat.done && out_stall, stat.done, "levels dropped in stall")
	`MSS_ASSERT_NOW(a_level_range, out_valid_q, volt_ok, "voltage level out of range")

endmodule

`default_nettype wire

>>> rtl/mss_sine_lut.sv
`default_nettype none

module mss_sine_lut (
	input  wire logic                             clk,
	input  wire logic                             rd_en,
	input  wire logic [mss_pkg::PHASE_BITS-1:0]   phase,
	output logic      [mss_pkg::MAG_BITS-1:0]     mag_q,
	output logic                                  neg_q
);

	logic [mss_pkg::MAG_BITS-1:0]       rom [mss_pkg::TABLE_SIZE];
	logic [1:0]                         quad;
	logic [mss_pkg::SINE_ADDR_BITS-1:0] addr;
	logic [mss_pkg::SINE_ADDR_BITS-1:0] addr_fold;

	// quarter-wave rom contents
	for (genvar k = 0; k < mss_pkg::TABLE_SIZE; k++) begin : g_rom
		assign rom[k] = mss_pkg::sine_entry(k);
	end

	// quadrant from the top phase bits, odd quadrants read mirrored
	assign quad      = phase[mss_pkg::PHASE_BITS-1 -: 2];
	assign addr      = phase[mss_pkg::PHASE_BITS-3 -: mss_pkg::SINE_ADDR_BITS];
	assign addr_fold = quad[0] ? ~addr : addr;

	// registered rom read, lower half of the wave is negative
	always_ff @(posedge clk) begin
		if (rd_en) begin
			mag_q <= rom[addr_fold];
			neg_q <= quad[1];
		end
	end

endmodule

`default_nettype wire

>>> rtl/mss_mul.sv
`default_nettype none

module mss_mul (
	input  wire logic                            clk,
	input  wire logic [mss_pkg::MUL_A_BITS-1:0]  a,
	input  wire logic [mss_pkg::MUL_B_BITS-1:0]  b,
	output logic      [mss_pkg::MUL_P_BITS-1:0]  p_q
);

	// unsigned product, registered
	always_ff @(posedge clk) begin
		p_q <= mss_pkg::MUL_P_BITS'(a) * mss_pkg::MUL_P_BITS'(b);
	end

endmodule

`default_nettype wire

>>> rtl/mss_seq.sv
`default_nettype none

module mss_seq (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic                          load_on,
	input  wire logic [mss_pkg::MAG_BITS-1:0]  mag,
	input  wire logic                          neg,
	input  wire mss_pkg::factor_arr_t          factor,
	input  wire logic                          take,
	output mss_pkg::seq_stat_t                 stat,
	output mss_pkg::lvl_arr_t                  lvl
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BASE,
		ST_SCALE,
		ST_RECIP,
		ST_FINISH,
		ST_DONE
	} state_t;

	localparam logic [mss_pkg::LVL_IDX_BITS-1:0] LAST = mss_pkg::LVL_IDX_BITS'(mss_pkg::LEVELS - 1);

	state_t                                state_q;
	logic [mss_pkg::LVL_IDX_BITS-1:0]      ch_q;
	logic                                  load_q;
	logic [mss_pkg::BASE_BITS-1:0]         base_q;
	mss_pkg::lvl_arr_t                     lvl_q;

	logic [mss_pkg::MUL_A_BITS-1:0]        mul_a;
	logic [mss_pkg::MUL_B_BITS-1:0]        mul_b;
	logic [mss_pkg::MUL_P_BITS-1:0]        p_q;
	logic [mss_pkg::F_BITS-1:0]            fac;
	logic [mss_pkg::N_BITS-1:0]            num;
	logic [mss_pkg::LVL_IDX_BITS-1:0]      lvl_idx;
	logic [mss_pkg::Q_V_BITS-1:0]          q_v;
	logic [mss_pkg::Q_I_BITS-1:0]          q_i;
	logic [mss_pkg::OFF_BITS-1:0]          off;
	logic [mss_pkg::MV_BITS-1:0]           level;

	mss_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	// current channels carry no amplitude without load
	assign fac = (ch_q == '0 || load_q) ? factor[ch_q] : '0;

	// round half up: drop the fraction, add half the divisor
	assign num = mss_pkg::N_BITS'(p_q[mss_pkg::P_BITS-1:mss_pkg::FRAC_SHIFT])
		+ ((ch_q == '0) ? mss_pkg::N_BITS'(mss_pkg::V_DEN / 2)
			: mss_pkg::N_BITS'(mss_pkg::I_DEN / 2));

	// shared multiplier operands per step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_BASE: begin
				mul_a = mss_pkg::MUL_A_BITS'(mag);
				mul_b = mss_pkg::MUL_B_BITS'(mss_pkg::SQRT2_Q16);
			end
			ST_SCALE: begin
				mul_a = (ch_q == '0) ? mss_pkg::MUL_A_BITS'(p_q[mss_pkg::BASE_BITS-1:0])
					: mss_pkg::MUL_A_BITS'(base_q);
				mul_b = mss_pkg::MUL_B_BITS'(fac);
			end
			ST_RECIP: begin
				mul_a = mss_pkg::MUL_A_BITS'(num);
				mul_b = (ch_q == '0) ? mss_pkg::MUL_B_BITS'(mss_pkg::M_V)
					: mss_pkg::MUL_B_BITS'(mss_pkg::M_I);
			end
			default: begin
			end
		endcase
	end

	// level of the channel whose quotient sits in the product register
	assign lvl_idx = (state_q == ST_FINISH) ? ch_q : mss_pkg::LVL_IDX_BITS'(ch_q - 1'b1);
	assign q_v     = p_q[mss_pkg::MUL_P_BITS-1:mss_pkg::S_V];
	assign q_i     = p_q[mss_pkg::MUL_P_BITS-1:mss_pkg::S_I];

	// offset saturates where the level would leave its range
	always_comb begin
		if (lvl_idx == '0) begin
			off = (q_v > mss_pkg::Q_V_BITS'(mss_pkg::OFF_MAX))
				? mss_pkg::OFF_BITS'(mss_pkg::OFF_MAX) : mss_pkg::OFF_BITS'(q_v);
		end else begin
			off = (q_i > mss_pkg::Q_I_BITS'(mss_pkg::OFF_MAX))
				? mss_pkg::OFF_BITS'(mss_pkg::OFF_MAX) : mss_pkg::OFF_BITS'(q_i);
		end
	end

	assign level = neg ? mss_pkg::MV_BITS'(mss_pkg::BIAS_MV) - mss_pkg::MV_BITS'(off)
		: mss_pkg::MV_BITS'(mss_pkg::BIAS_MV) + mss_pkg::MV_BITS'(off);

	// sequencer: one sine scale, then scale and divide per level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= '0;
			load_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						load_q  <= load_on;
						state_q <= ST_BASE;
					end
				end
				ST_BASE: begin
					ch_q    <= '0;
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					if (ch_q == '0) begin
						base_q <= p_q[mss_pkg::BASE_BITS-1:0];
					end else begin
						lvl_q[lvl_idx] <= level;
					end
					state_q <= ST_RECIP;
				end
				ST_RECIP: begin
					if (ch_q == LAST) begin
						state_q <= ST_FINISH;
					end else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= ST_SCALE;
					end
				end
				ST_FINISH: begin
					lvl_q[lvl_idx] <= level;
					state_q        <= ST_DONE;
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_DONE);
	assign lvl       = lvl_q;

endmodule

`default_nettype wire
